FILE: src/ucs_pkg.sv
package ucs_pkg;

    localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE  = 8'hF0;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_CODE   = 8'h80;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] ROOM_RESET  = 16'hFFFF;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_JUNK
    } byte_class_t;

    typedef struct packed {
        logic [15:0] char_count;
        logic [15:0] fit_bytes;
        logic        well_formed;
    } ucs_result_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cls;
        if (b == 8'h00) begin
            cls = CLS_END;
        end
        else if (!b[7]) begin
            cls = CLS_ASCII;
        end
        else if ((b & CONT_MASK) == CONT_CODE) begin
            cls = CLS_CONT;
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            cls = CLS_LEAD2;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            cls = CLS_LEAD3;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            cls = CLS_LEAD4;
        end
        else begin
            cls = CLS_JUNK;
        end
        return cls;
    endfunction

endpackage

FILE: src/ucs_if.sv
interface ucs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface ucs_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_count;
    logic [15:0] fit_bytes;
    logic        well_formed;

    modport source (output valid, output char_count, output fit_bytes,
                    output well_formed, input ready);
    modport sink (input valid, input char_count, input fit_bytes,
                  input well_formed, output ready);
endinterface

interface ucs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] fit_room;

    modport source (output valid, output fit_room, input ready);
    modport sink (input valid, input fit_room, output ready);
endinterface

FILE: src/ucs_core.sv
module ucs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         fit_room,
    output ucs_pkg::ucs_result_t result
);
    import ucs_pkg::*;

    logic [2:0]  seq_want_reg;
    logic [2:0]  seq_want_next;
    logic [1:0]  seq_have_reg;
    logic [1:0]  seq_have_next;
    logic [15:0] chars_reg;
    logic [15:0] chars_next;
    logic [15:0] bytes_reg;
    logic [15:0] bytes_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic        junk_reg;
    logic        junk_next;

    byte_class_t cls;
    logic        seq_open;
    logic        complete;
    logic [2:0]  have_inc;
    logic [2:0]  flush_n;
    logic [2:0]  take_n;
    logic [2:0]  need;
    logic [16:0] room_gap;
    logic [15:0] avail;
    logic [16:0] chars_sum;

    always_comb
    begin
        cls           = classify(data_byte);
        seq_open      = (seq_want_reg != 3'd0);
        have_inc      = {1'b0, seq_have_reg} + 3'd1;
        complete      = 1'b0;
        flush_n       = 3'd0;
        take_n        = 3'd0;
        need          = 3'd0;
        seq_want_next = seq_want_reg;
        seq_have_next = seq_have_reg;
        junk_next     = junk_reg;
        stopped_next  = stopped_reg;
        bytes_next    = bytes_reg;

        if (seq_open && (cls == CLS_CONT))
        begin
            if (have_inc >= seq_want_reg)
            begin
                complete      = 1'b1;
                take_n        = 3'd1;
                need          = seq_want_reg;
                seq_want_next = 3'd0;
                seq_have_next = 2'd0;
            end
            else
            begin
                seq_have_next = have_inc[1:0];
            end
        end
        else
        begin
            // An unfinished sequence is released byte by byte as junk.
            if (seq_open)
            begin
                flush_n = {1'b0, seq_have_reg};
            end
            if (flush_n != 3'd0)
            begin
                junk_next = 1'b1;
            end
            take_n        = flush_n;
            seq_want_next = 3'd0;
            seq_have_next = 2'd0;
            case (cls)
                CLS_ASCII:
                begin
                    take_n = flush_n + 3'd1;
                end
                CLS_LEAD2:
                begin
                    seq_want_next = 3'd2;
                    seq_have_next = 2'd1;
                end
                CLS_LEAD3:
                begin
                    seq_want_next = 3'd3;
                    seq_have_next = 2'd1;
                end
                CLS_LEAD4:
                begin
                    seq_want_next = 3'd4;
                    seq_have_next = 2'd1;
                end
                CLS_CONT, CLS_JUNK:
                begin
                    take_n    = flush_n + 3'd1;
                    junk_next = 1'b1;
                end
                default:
                begin
                    take_n = flush_n;
                end
            endcase
            need = take_n;
        end

        room_gap = {1'b0, fit_room} - {1'b0, bytes_reg};
        avail    = room_gap[16] ? 16'd0 : room_gap[15:0];
        if (!stopped_reg && (need != 3'd0))
        begin
            if (avail >= {13'd0, need})
            begin
                bytes_next = bytes_reg + {13'd0, need};
            end
            else
            begin
                // Single-byte junk characters fit one at a time until the room runs out.
                stopped_next = 1'b1;
                if (!complete)
                begin
                    bytes_next = bytes_reg + {13'd0, avail[2:0]};
                end
            end
        end

        chars_sum  = {1'b0, chars_reg} + {14'd0, take_n};
        chars_next = chars_sum[16] ? COUNT_MAX : chars_sum[15:0];

        result.char_count  = chars_next;
        result.fit_bytes   = bytes_next;
        result.well_formed = !junk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_want_reg <= 3'd0;
            seq_have_reg <= 2'd0;
            chars_reg    <= 16'd0;
            bytes_reg    <= 16'd0;
            stopped_reg  <= 1'b0;
            junk_reg     <= 1'b0;
        end
        else if (step)
        begin
            if (cls == CLS_END)
            begin
                seq_want_reg <= 3'd0;
                seq_have_reg <= 2'd0;
                chars_reg    <= 16'd0;
                bytes_reg    <= 16'd0;
                stopped_reg  <= 1'b0;
                junk_reg     <= 1'b0;
            end
            else
            begin
                seq_want_reg <= seq_want_next;
                seq_have_reg <= seq_have_next;
                chars_reg    <= chars_next;
                bytes_reg    <= bytes_next;
                stopped_reg  <= stopped_next;
                junk_reg     <= junk_next;
            end
        end
    end

endmodule

FILE: src/utf8_char_scan_fit_check.sv
// UTF-8 character scanner with a byte budget check.
//
// The stream channel carries one string byte per transaction; a zero byte
// ends the string. For each zero byte the result channel delivers one
// transaction with the character count, the bytes of the leading whole
// characters that fit the budget, and the well-formed flag. The cfg channel
// writes the byte budget and is always ready; write it only while no string
// is in progress.
//
// A byte is held in an input register and scanned from there; the result
// of a zero byte is registered in the output register and offered from it.
// One byte is accepted every cycle unless a zero byte waits in the input
// register; the combinational scan of the input register against the
// string state sets that rate.
// Reset clears the string state and the pipeline and sets the budget to
// 65535. When the receiver stalls, the result is held in the output register
// and non-zero bytes keep flowing; a second zero byte waits in the input
// register until the output register is free.
module utf8_char_scan_fit_check (
    input logic          clk,
    input logic          rst_n,
    ucs_byte_if.sink     stream,
    ucs_result_if.source result,
    ucs_cfg_if.sink      cfg
);
    import ucs_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [15:0] room_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    ucs_result_t out_reg;
    ucs_result_t core_result;
    logic        out_free;
    logic        is_end;
    logic        advance;

    assign out_free = !out_valid_reg || result.ready;
    assign is_end   = (in_byte_reg == 8'h00);
    assign advance  = in_valid_reg && (!is_end || out_free);

    assign stream.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.char_count  = out_reg.char_count;
    assign result.fit_bytes   = out_reg.fit_bytes;
    assign result.well_formed = out_reg.well_formed;

    ucs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .fit_room  (room_reg),
        .result    (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (stream.valid && stream.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            room_reg      <= ROOM_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                room_reg <= cfg.fit_room;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.data_byte;
        end
        if (advance && is_end)
        begin
            out_reg <= core_result;
        end
    end

endmodule

FILE: src/ucs_checker.sv
module ucs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] char_count,
    input logic [15:0] fit_bytes,
    input logic        well_formed
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(char_count) && $stable(fit_bytes)
            && $stable(well_formed))
        else $error("result payload changed while stalled");

    // No character is longer than four bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({2'b00, fit_bytes} <= {char_count, 2'b00}))
        else $error("fitted bytes exceed four per character");

    // An empty string is well formed and fits nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (char_count == 16'd0) |-> well_formed && (fit_bytes == 16'd0))
        else $error("empty string result is inconsistent");

endmodule

bind utf8_char_scan_fit_check ucs_checker u_ucs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .char_count  (result.char_count),
    .fit_bytes   (result.fit_bytes),
    .well_formed (result.well_formed)
);
